// ===== hdl/tcc_pkg.sv =====
// shared types and constants of the text console cursor engine
`timescale 1ns / 1ps
package tcc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDE_MODE    = 3'd0;
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_MAX_COLUMNS  = 3'd3;
  localparam logic [2:0] CFG_MAX_ROWS     = 3'd4;
  localparam logic [2:0] CFG_CLEAR_ENABLE = 3'd5;

  // wide_mode codes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_SJIS   = 2'd1;
  localparam logic [1:0] MODE_EUC    = 2'd2;

  // input opcodes
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // control characters
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] EUC_SS2  = 8'h8E;

  localparam logic [10:0] TAB_PIXEL      = 11'(480 - 64 - 16 - 16 - 16);
  localparam logic [4:0]  NARROW_ADVANCE = 5'd7;

  typedef enum logic [1:0] {
    CMD_NARROW = 2'd0,
    CMD_WIDE   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // classified action handed from front to back
  typedef enum logic [2:0] {
    ACT_SET,
    ACT_CR,
    ACT_LF,
    ACT_TAB,
    ACT_LEAD,
    ACT_CHAR,
    ACT_WIDE,
    ACT_EUC_NARROW
  } act_t;

  typedef struct packed {
    logic [1:0] wide_mode;
    logic [4:0] glyph_width;
    logic [5:0] glyph_height;
    logic [6:0] max_columns;
    logic [5:0] max_rows;
    logic       clear_enable;
  } cfg_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] code1;
    logic [7:0] code2;
    logic       eob;
    logic [6:0] new_column;
    logic [5:0] new_row;
  } entry_t;

endpackage

// ===== hdl/tcc_front.sv =====
// front end: accepts items, tracks lead bytes and classifies each item
`timescale 1ns / 1ps
module tcc_front
  import tcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       push,
  input  logic       opcode,
  input  logic [7:0] text_byte,
  input  logic       end_of_buffer,
  input  logic [6:0] new_column,
  input  logic [5:0] new_row,
  output entry_t     entry
);

  logic       lead_pending;
  logic [7:0] lead_value;
  logic       lead_pending_next;
  logic       is_lead;

  always_comb begin
    unique case (cfg.wide_mode)
      MODE_SJIS: is_lead = (text_byte >= 8'h81 && text_byte <= 8'h9F) ||
                           (text_byte >= 8'hE0 && text_byte <= 8'hEA) ||
                           (text_byte >= 8'hFA && text_byte <= 8'hFC);
      MODE_EUC:  is_lead = (text_byte == EUC_SS2) ||
                           (text_byte >= 8'hA1 && text_byte <= 8'hAD) ||
                           (text_byte >= 8'hB0 && text_byte <= 8'hF4) ||
                           (text_byte >= 8'hF9 && text_byte <= 8'hFC);
      default:   is_lead = 1'b0;
    endcase
  end

  always_comb begin
    entry.code1      = text_byte;
    entry.code2      = 8'h00;
    entry.eob        = end_of_buffer;
    entry.new_column = new_column;
    entry.new_row    = new_row;
    lead_pending_next = 1'b0;
    if (opcode == OP_SET) begin
      entry.act = ACT_SET;
    end else if (lead_pending) begin
      // any byte after a lead is its trail
      if (lead_value == EUC_SS2 && cfg.wide_mode == MODE_EUC) begin
        entry.act = ACT_EUC_NARROW;
      end else begin
        entry.act   = ACT_WIDE;
        entry.code1 = lead_value;
        entry.code2 = text_byte;
      end
    end else if (text_byte == CHAR_CR) begin
      entry.act = ACT_CR;
    end else if (text_byte == CHAR_LF) begin
      entry.act = ACT_LF;
    end else if (text_byte == CHAR_TAB) begin
      entry.act = ACT_TAB;
    end else if (is_lead) begin
      entry.act = ACT_LEAD;
      lead_pending_next = 1'b1;
    end else begin
      entry.act = ACT_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      lead_value   <= 8'h00;
    end else if (push) begin
      lead_pending <= lead_pending_next;
      if (lead_pending_next) begin
        lead_value <= text_byte;
      end
    end
  end

endmodule

// ===== hdl/tcc_queue.sv =====
// short queue of classified items between front and back
`timescale 1ns / 1ps
module tcc_queue
  import tcc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/tcc_back.sv =====
// back end: cursor state, glyph and clear-row result generation
`timescale 1ns / 1ps
module tcc_back
  import tcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  command,
  output logic [10:0] pixel_x,
  output logic [10:0] pixel_y,
  output logic [7:0]  first_code,
  output logic [7:0]  second_code,
  output logic        last
);

  logic [6:0]  cursor_column;
  logic [5:0]  cursor_row;
  logic [10:0] pixel_column;
  logic        clear_pending;

  logic [6:0]  cursor_column_next;
  logic [5:0]  cursor_row_next;
  logic [10:0] pixel_column_next;

  logic        out_free;
  logic        is_glyph;
  logic        advance_col;
  logic [6:0]  col_inc;
  logic        wrap;
  logic        row_adv;
  logic [5:0]  row_inc;
  logic        clear_need;
  logic        load_glyph;
  logic        load_clear;
  logic [9:0]  col_times7;
  logic [9:0]  next_col_times7;
  logic [10:0] glyph_x;
  logic [4:0]  glyph_adv;
  logic [11:0] row_product;
  cmd_t        glyph_cmd;

  assign out_free = !result_valid || !result_stall;

  assign is_glyph = (head.act == ACT_CHAR) || (head.act == ACT_WIDE) ||
                    (head.act == ACT_EUC_NARROW);
  assign advance_col = is_glyph || (head.act == ACT_TAB);
  assign col_inc     = cursor_column + 7'd1;
  assign wrap        = advance_col && (col_inc == cfg.max_columns);
  assign row_adv     = wrap || (head.act == ACT_LF);
  assign row_inc     = cursor_row + 6'd1;
  assign clear_need  = row_adv && cfg.clear_enable;

  // an item with a glyph needs the output register, the rest go straight through
  assign pop        = head_valid && !clear_pending && (!is_glyph || out_free);
  assign load_glyph = pop && is_glyph;
  assign load_clear = clear_pending && out_free;

  // times seven as shift and subtract
  assign col_times7      = {cursor_column, 3'b000} - {3'b000, cursor_column};
  assign next_col_times7 = {cursor_column_next, 3'b000} - {3'b000, cursor_column_next};

  always_comb begin
    glyph_x   = pixel_column;
    glyph_adv = NARROW_ADVANCE;
    glyph_cmd = CMD_NARROW;
    unique case (head.act)
      ACT_CHAR: begin
        if (cfg.wide_mode == MODE_SINGLE) begin
          glyph_x   = {1'b0, col_times7};
          glyph_adv = cfg.glyph_width;
        end
      end
      ACT_WIDE: begin
        glyph_adv = cfg.glyph_width;
        glyph_cmd = CMD_WIDE;
      end
      default: ;
    endcase
  end

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    unique case (head.act)
      ACT_SET: begin
        if (head.new_column < cfg.max_columns) cursor_column_next = head.new_column;
        if (head.new_row < cfg.max_rows) cursor_row_next = head.new_row;
      end
      ACT_CR, ACT_LF: cursor_column_next = 7'd0;
      default: begin
        if (advance_col) cursor_column_next = wrap ? 7'd0 : col_inc;
      end
    endcase
    if (row_adv) begin
      cursor_row_next = (row_inc == cfg.max_rows) ? 6'd0 : row_inc;
    end
  end

  always_comb begin
    pixel_column_next = pixel_column;
    unique case (head.act)
      ACT_CR, ACT_LF: pixel_column_next = 11'd0;
      ACT_TAB:        pixel_column_next = wrap ? 11'd0 : TAB_PIXEL;
      ACT_CHAR, ACT_WIDE, ACT_EUC_NARROW:
        pixel_column_next = wrap ? 11'd0 : glyph_x + {6'd0, glyph_adv};
      default: ;
    endcase
    if (head.act == ACT_SET || head.eob) begin
      pixel_column_next = {1'b0, next_col_times7};
    end
  end

  // row register is already advanced when a clear result is loaded
  assign row_product = cursor_row * cfg.glyph_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 7'd0;
      cursor_row    <= 6'd0;
      pixel_column  <= 11'd0;
      clear_pending <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (pop) begin
        cursor_column <= cursor_column_next;
        cursor_row    <= cursor_row_next;
        pixel_column  <= pixel_column_next;
        clear_pending <= clear_need;
      end else if (load_clear) begin
        clear_pending <= 1'b0;
      end
      if (out_free) begin
        result_valid <= load_glyph || load_clear;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_glyph) begin
      command     <= glyph_cmd;
      pixel_x     <= glyph_x;
      pixel_y     <= row_product[10:0];
      first_code  <= head.code1;
      second_code <= head.code2;
      last        <= !clear_need;
    end else if (load_clear) begin
      command     <= CMD_CLEAR;
      pixel_x     <= 11'd0;
      pixel_y     <= row_product[10:0];
      first_code  <= 8'h00;
      second_code <= 8'h00;
      last        <= 1'b1;
    end
  end

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// top level of the text console cursor engine
`timescale 1ns / 1ps
//
//  channel   handshake                 payload
//  item      item_valid / item_stall   opcode text_byte end_of_buffer new_column new_row
//  result    result_valid/result_stall command pixel_x pixel_y first_code second_code last
//  config    cfg_write                 cfg_index cfg_data
//
//  an item is taken every cycle while the queue has room; the back end pops
//  an item only while no clear-row result is pending, so an item that also clears
//  a row (a column wrap or a line feed with clears on) holds it until that clear is loaded
//  the back end's single output register paces results at one per cycle while result_stall is low
//  rst is synchronous and clears cursor, pixel column, lead byte and queue;
//  registers return to their documented defaults
//  result_stall holds the output register; the queue fills, then item_stall rises
//
module text_console_cursor_engine
  import tcc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic [7:0]  text_byte,
  input  logic        end_of_buffer,
  input  logic [6:0]  new_column,
  input  logic [5:0]  new_row,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  command,
  output logic [10:0] pixel_x,
  output logic [10:0] pixel_y,
  output logic [7:0]  first_code,
  output logic [7:0]  second_code,
  output logic        last
);

  cfg_t   cfg;
  entry_t front_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   head_valid;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wide_mode    <= MODE_SINGLE;
      cfg.glyph_width  <= 5'd7;
      cfg.glyph_height <= 6'd14;
      cfg.max_columns  <= 7'd68;
      cfg.max_rows     <= 6'd18;
      cfg.clear_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDE_MODE:    cfg.wide_mode    <= cfg_data[1:0];
        CFG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[4:0];
        CFG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        CFG_MAX_COLUMNS:  cfg.max_columns  <= cfg_data;
        CFG_MAX_ROWS:     cfg.max_rows     <= cfg_data[5:0];
        CFG_CLEAR_ENABLE: cfg.clear_enable <= cfg_data[0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // stall only on a full queue, never on valid
  assign item_stall = q_full;
  assign push       = item_valid && !item_stall;

  // front: lead byte tracking and classification
  tcc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .opcode        (opcode),
    .text_byte     (text_byte),
    .end_of_buffer (end_of_buffer),
    .new_column    (new_column),
    .new_row       (new_row),
    .entry         (front_entry)
  );

  // decoupling queue
  tcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (front_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: cursor state and result generation
  tcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .command      (command),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .first_code   (first_code),
    .second_code  (second_code),
    .last         (last)
  );

  // a clear-row result always closes its transaction group
  a_clear_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && command == CMD_CLEAR |-> last)
    else $error("clear-row result without last");

  // a result that is not last is followed by its partner without a gap
  a_partner_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("gap after a non-final result");

  // narrow glyphs carry no trail byte
  a_narrow_no_trail: assert property (@(posedge clk) disable iff (rst)
    result_valid && command == CMD_NARROW |-> second_code == 8'h00)
    else $error("narrow glyph with trail byte");

  // the back end never pops an empty queue
  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== test/text_console_cursor_engine_test.sv =====
// self-checking testbench of the text console cursor engine: directed table, then random phases
`timescale 1ns / 1ps
module text_console_cursor_engine_test;
  import tcc_pkg::*;

  // run shape
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 97;
  localparam int SETTLE_CYCLES   = 12;      // lets the queue and back end drain, with margin
  localparam int CYCLE_LIMIT     = 1000000;

  // wide_mode value with no name in the package: single byte with fixed advance
  localparam logic [1:0] MODE_THREE = 2'd3;

  // lead byte ranges of the two double-byte encodings
  localparam logic [7:0] SJIS_A_LO = 8'h81;
  localparam logic [7:0] SJIS_A_HI = 8'h9F;
  localparam logic [7:0] SJIS_B_LO = 8'hE0;
  localparam logic [7:0] SJIS_B_HI = 8'hEA;
  localparam logic [7:0] SJIS_C_LO = 8'hFA;
  localparam logic [7:0] SJIS_C_HI = 8'hFC;
  localparam logic [7:0] EUC_A_LO  = 8'hA1;
  localparam logic [7:0] EUC_A_HI  = 8'hAD;
  localparam logic [7:0] EUC_B_LO  = 8'hB0;
  localparam logic [7:0] EUC_B_HI  = 8'hF4;
  localparam logic [7:0] EUC_C_LO  = 8'hF9;
  localparam logic [7:0] EUC_C_HI  = 8'hFC;

  // one draw or clear command as it leaves the block
  typedef struct {
    cmd_t       command;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0] first_code;
    logic [7:0] second_code;
    logic       last;
  } draw_t;

  typedef enum logic [1:0] {
    ROW_TEXT,
    ROW_SET,
    ROW_REG
  } row_kind_t;

  // one line of the directed table; random transactions reuse the same shape
  typedef struct {
    row_kind_t  kind;
    logic [7:0] code;
    logic       eob;
    logic [6:0] col;
    logic [5:0] row;
    logic [2:0] reg_index;
    logic [6:0] reg_value;
    logic       has_literal;
    draw_t      literal;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        item_valid;
  logic        item_stall;
  logic        opcode;
  logic [7:0]  text_byte;
  logic        end_of_buffer;
  logic [6:0]  new_column;
  logic [5:0]  new_row;
  logic        result_valid;
  logic        result_stall;
  logic [1:0]  command;
  logic [10:0] pixel_x;
  logic [10:0] pixel_y;
  logic [7:0]  first_code;
  logic [7:0]  second_code;
  logic        last;

  text_console_cursor_engine u_dut (.*);

  // shadow of the register file and of the cursor state
  cfg_t        shadow_cfg;
  logic [6:0]  cursor_col;
  logic [5:0]  cursor_row;
  logic [10:0] pixel_col;
  logic        lead_waiting;
  logic [7:0]  lead_byte;

  draw_t       expected_draws[$];   // commands still owed by the block, oldest first
  draw_t       step_draws[$];       // commands caused by the transaction being predicted
  stim_row_t   directed_rows[$];
  int          mismatch_count;
  bit          quiet;               // phase with no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_draw(cmd_t cmd, logic [10:0] px, logic [7:0] b1, logic [7:0] b2);
    draw_t d;
    d.command     = cmd;
    d.pixel_x     = px;
    // row times height, kept to 11 bits
    d.pixel_y     = 11'(int'(cursor_row) * int'(shadow_cfg.glyph_height));
    d.first_code  = b1;
    d.second_code = b2;
    d.last        = 1'b0;
    step_draws.push_back(d);
  endfunction

  // row counts modulo 64 before the compare, so a max of zero wraps after 64 rows
  function automatic void advance_row();
    cursor_row = cursor_row + 6'd1;
    if (cursor_row == shadow_cfg.max_rows) cursor_row = '0;
    if (shadow_cfg.clear_enable) add_draw(CMD_CLEAR, '0, '0, '0);
  endfunction

  function automatic void advance_column();
    cursor_col = cursor_col + 7'd1;
    if (cursor_col == shadow_cfg.max_columns) begin
      cursor_col = '0;
      pixel_col  = '0;
      advance_row();
    end
  endfunction

  function automatic logic starts_pair(logic [7:0] c);
    case (shadow_cfg.wide_mode)
      MODE_SJIS: begin
        return (c >= SJIS_A_LO && c <= SJIS_A_HI) || (c >= SJIS_B_LO && c <= SJIS_B_HI) ||
               (c >= SJIS_C_LO && c <= SJIS_C_HI);
      end
      MODE_EUC: begin
        return c == EUC_SS2 || (c >= EUC_A_LO && c <= EUC_A_HI) ||
               (c >= EUC_B_LO && c <= EUC_B_HI) || (c >= EUC_C_LO && c <= EUC_C_HI);
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [10:0] column_pixel();
    return 11'(int'(cursor_col) * int'(NARROW_ADVANCE));
  endfunction

  // fills step_draws with what one accepted transaction makes the block emit
  function automatic void predict_draws(stim_row_t r);
    step_draws.delete();
    if (r.kind == ROW_SET) begin
      // out-of-range coordinates keep their old value; a waiting lead byte is dropped
      if (r.col < shadow_cfg.max_columns) cursor_col = r.col;
      if (r.row < shadow_cfg.max_rows) cursor_row = r.row;
      lead_waiting = 1'b0;
      pixel_col    = column_pixel();
    end else begin
      if (lead_waiting) begin
        // any byte completes the pair, control characters included
        lead_waiting = 1'b0;
        if (lead_byte == EUC_SS2 && shadow_cfg.wide_mode == MODE_EUC) begin
          add_draw(CMD_NARROW, pixel_col, r.code, '0);
          pixel_col = pixel_col + 11'(NARROW_ADVANCE);
        end else begin
          add_draw(CMD_WIDE, pixel_col, lead_byte, r.code);
          pixel_col = pixel_col + 11'(shadow_cfg.glyph_width);
        end
        advance_column();
      end else if (r.code == CHAR_CR) begin
        cursor_col = '0;
        pixel_col  = '0;
      end else if (r.code == CHAR_LF) begin
        cursor_col = '0;
        pixel_col  = '0;
        advance_row();
      end else if (r.code == CHAR_TAB) begin
        pixel_col = TAB_PIXEL;
        advance_column();
      end else if (starts_pair(r.code)) begin
        lead_waiting = 1'b1;
        lead_byte    = r.code;
      end else begin
        // single byte mode redraws from the cell; the others keep the running pixel
        if (shadow_cfg.wide_mode == MODE_SINGLE) pixel_col = column_pixel();
        add_draw(CMD_NARROW, pixel_col, r.code, '0);
        if (shadow_cfg.wide_mode == MODE_SINGLE) begin
          pixel_col = pixel_col + 11'(shadow_cfg.glyph_width);
        end else begin
          pixel_col = pixel_col + 11'(NARROW_ADVANCE);
        end
        advance_column();
      end
      // end of a print call pulls the pixel column back onto the grid
      if (r.eob) pixel_col = column_pixel();
    end
    if (step_draws.size() > 0) step_draws[step_draws.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- table rows

  function automatic stim_row_t text_row(logic [7:0] code, logic eob);
    stim_row_t r;
    r.kind        = ROW_TEXT;
    r.code        = code;
    r.eob         = eob;
    r.col         = 7'(8'($urandom_range(0, 255)));
    r.row         = 6'(8'($urandom_range(0, 255)));
    r.reg_index   = CFG_WIDE_MODE;
    r.reg_value   = '0;
    r.has_literal = 1'b0;
    r.literal.command     = CMD_NARROW;
    r.literal.pixel_x     = '0;
    r.literal.pixel_y     = '0;
    r.literal.first_code  = '0;
    r.literal.second_code = '0;
    r.literal.last        = 1'b0;
    return r;
  endfunction

  // a text transaction whose single command is written out by hand
  function automatic stim_row_t lit_row(logic [7:0] code, logic eob, cmd_t cmd, int px, int py,
                                        logic [7:0] b1, logic [7:0] b2);
    stim_row_t r;
    r = text_row(code, eob);
    r.has_literal         = 1'b1;
    r.literal.command     = cmd;
    r.literal.pixel_x     = 11'(px);
    r.literal.pixel_y     = 11'(py);
    r.literal.first_code  = b1;
    r.literal.second_code = b2;
    r.literal.last        = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t set_row(int col, int row);
    stim_row_t r;
    r = text_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    r.kind = ROW_SET;
    r.col  = 7'(col);
    r.row  = 6'(row);
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] idx, int value);
    stim_row_t r;
    r = text_row('0, 1'b0);
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_value = 7'(value);
    return r;
  endfunction

  // ---------------------------------------------------------------- random stimulus

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  // lead bytes of the current encoding, so most pairs are well formed
  function automatic logic [7:0] pick_lead_byte();
    int k;
    if (shadow_cfg.wide_mode == MODE_SJIS) k = int'($urandom_range(0, 2));
    else if (shadow_cfg.wide_mode == MODE_EUC) k = int'($urandom_range(3, 6));
    else k = int'($urandom_range(0, 6));
    case (k)
      0:       return 8'($urandom_range(SJIS_A_LO, SJIS_A_HI));
      1:       return 8'($urandom_range(SJIS_B_LO, SJIS_B_HI));
      2:       return 8'($urandom_range(SJIS_C_LO, SJIS_C_HI));
      3:       return EUC_SS2;
      4:       return 8'($urandom_range(EUC_A_LO, EUC_A_HI));
      5:       return 8'($urandom_range(EUC_B_LO, EUC_B_HI));
      default: return 8'($urandom_range(EUC_C_LO, EUC_C_HI));
    endcase
  endfunction

  function automatic stim_row_t random_row();
    int         r;
    int         col;
    int         row;
    logic       eob;
    logic [7:0] code;
    r   = int'($urandom_range(0, 99));
    eob = ($urandom_range(0, 99) < 15);
    if (r < 8) begin
      // mostly legal coordinates, the rest anywhere in the field
      col = int'($urandom_range(0, 127));
      row = int'($urandom_range(0, 63));
      if ($urandom_range(0, 3) != 0 && shadow_cfg.max_columns != 0)
        col = int'($urandom_range(0, shadow_cfg.max_columns - 1));
      if ($urandom_range(0, 3) != 0 && shadow_cfg.max_rows != 0)
        row = int'($urandom_range(0, shadow_cfg.max_rows - 1));
      return set_row(col, row);
    end
    if (r < 11) code = CHAR_CR;
    else if (r < 15) code = CHAR_LF;
    else if (r < 19) code = CHAR_TAB;
    else if (r < 55) code = pick_lead_byte();
    else code = 8'($urandom_range(0, 255));
    return text_row(code, eob);
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic write_reg(logic [2:0] idx, logic [6:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_WIDE_MODE:    shadow_cfg.wide_mode    = value[1:0];
      CFG_GLYPH_WIDTH:  shadow_cfg.glyph_width  = value[4:0];
      CFG_GLYPH_HEIGHT: shadow_cfg.glyph_height = value[5:0];
      CFG_MAX_COLUMNS:  shadow_cfg.max_columns  = value[6:0];
      CFG_MAX_ROWS:     shadow_cfg.max_rows     = value[5:0];
      CFG_CLEAR_ENABLE: shadow_cfg.clear_enable = value[0];
      default: ;
    endcase
  endtask

  // drop valid, let every owed command come out, then give commandless
  // transactions time to leave the queue before touching a register
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_transaction(stim_row_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid    <= 1'b1;
    opcode        <= (r.kind == ROW_SET) ? OP_SET : OP_TEXT;
    text_byte     <= r.code;
    end_of_buffer <= r.eob;
    new_column    <= r.col;
    new_row       <= r.row;
    // payload holds until the edge that takes it
    do @(posedge clk); while (item_stall);
    predict_draws(r);
    if (r.has_literal) begin
      expected_draws.push_back(r.literal);
    end else begin
      foreach (step_draws[i]) expected_draws.push_back(step_draws[i]);
    end
  endtask

  // one register setting per random phase; the first three are the extremes
  task automatic apply_setting(int phase);
    int mode;
    int gw;
    int gh;
    int mc;
    int mr;
    int ce;
    case (phase)
      0: begin
        mode = MODE_SINGLE; gw = 1;  gh = 1;  mc = 1;   mr = 1;  ce = 0;
      end
      1: begin
        mode = MODE_EUC;    gw = 16; gh = 32; mc = 127; mr = 63; ce = 1;
      end
      2: begin
        // out of the documented range: zero max means wrap on counter overflow
        mode = MODE_THREE;  gw = 31; gh = 63; mc = 0;   mr = 0;  ce = 1;
      end
      default: begin
        mode = ($urandom_range(0, 9) == 0) ? MODE_THREE : int'($urandom_range(0, 2));
        gw   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 31))
                                           : int'($urandom_range(1, 16));
        gh   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 63))
                                           : int'($urandom_range(1, 32));
        // small limits make wraps frequent
        mc   = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 12))
                                           : int'($urandom_range(0, 127));
        mr   = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 6))
                                           : int'($urandom_range(0, 63));
        ce   = int'($urandom_range(0, 1));
      end
    endcase
    write_reg(CFG_WIDE_MODE, 7'(mode));
    write_reg(CFG_GLYPH_WIDTH, 7'(gw));
    write_reg(CFG_GLYPH_HEIGHT, 7'(gh));
    write_reg(CFG_MAX_COLUMNS, 7'(mc));
    write_reg(CFG_MAX_ROWS, 7'(mr));
    write_reg(CFG_CLEAR_ENABLE, 7'(ce));
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // every transaction on the result side is matched against the oldest owed command
  always @(posedge clk) begin
    draw_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_draws.size() == 0) begin
        $error("command %0d at x %0d y %0d with nothing owed", command, pixel_x, pixel_y);
        mismatch_count++;
      end else begin
        want = expected_draws.pop_front();
        check_field("command", 11'(want.command), 11'(command));
        check_field("pixel_x", want.pixel_x, pixel_x);
        check_field("pixel_y", want.pixel_y, pixel_y);
        check_field("first_code", 11'(want.first_code), 11'(first_code));
        check_field("second_code", 11'(want.second_code), 11'(second_code));
        check_field("last", 11'(want.last), 11'(last));
      end
    end
  end

  // result side back-pressure, in bursts of the same shape as the sender's gaps
  initial begin : result_pacing
    int hold;
    result_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) hold = pick_gap();
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- run

  initial begin : stimulus
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_WIDE_MODE;
    cfg_data      = '0;
    item_valid    = 1'b0;
    opcode        = OP_TEXT;
    text_byte     = '0;
    end_of_buffer = 1'b0;
    new_column    = '0;
    new_row       = '0;
    quiet         = 1'b0;
    mismatch_count = 0;

    // register defaults and cleared cursor state
    shadow_cfg.wide_mode    = MODE_SINGLE;
    shadow_cfg.glyph_width  = 5'd7;
    shadow_cfg.glyph_height = 6'd14;
    shadow_cfg.max_columns  = 7'd68;
    shadow_cfg.max_rows     = 6'd18;
    shadow_cfg.clear_enable = 1'b1;
    cursor_col   = '0;
    cursor_row   = '0;
    pixel_col    = '0;
    lead_waiting = 1'b0;
    lead_byte    = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_rows = '{
      // defaults after reset: 68 columns, 18 rows, 7 by 14 cells
      lit_row(8'h41, 1'b0, CMD_NARROW, 0, 0, 8'h41, 8'h00),
      lit_row(8'hFF, 1'b0, CMD_NARROW, 7, 0, 8'hFF, 8'h00),
      text_row(CHAR_CR, 1'b0),
      lit_row(CHAR_LF, 1'b0, CMD_CLEAR, 0, 14, 8'h00, 8'h00),
      text_row(CHAR_TAB, 1'b0),
      // end of buffer after the glyph resyncs the pixel column to the grid
      lit_row(8'h20, 1'b1, CMD_NARROW, 7, 14, 8'h20, 8'h00),
      lit_row(8'h00, 1'b0, CMD_NARROW, 14, 14, 8'h00, 8'h00),
      // bottom-right cell: glyph, column wrap, row wrap to the top with a clear
      set_row(67, 17),
      text_row(8'h7E, 1'b0),
      // both coordinates out of range: cursor stays put
      set_row(127, 63),
      reg_row(CFG_WIDE_MODE, MODE_SJIS),
      text_row(8'h81, 1'b0),
      lit_row(8'h40, 1'b0, CMD_WIDE, 0, 0, 8'h81, 8'h40),
      // control character taken as a trail byte
      text_row(8'hFC, 1'b0),
      text_row(CHAR_CR, 1'b0),
      reg_row(CFG_WIDE_MODE, MODE_EUC),
      // single shift two: half-width glyph of the trail byte
      text_row(EUC_SS2, 1'b0),
      text_row(8'hA1, 1'b0),
      text_row(8'hF4, 1'b0),
      text_row(8'hFE, 1'b0),
      // shift lead waiting while the mode leaves euc: drawn wide
      text_row(EUC_SS2, 1'b0),
      reg_row(CFG_WIDE_MODE, MODE_SJIS),
      text_row(8'h41, 1'b0),
      // cursor move throws away a waiting lead byte
      text_row(8'hE5, 1'b0),
      set_row(10, 5),
      text_row(8'h41, 1'b0),
      reg_row(CFG_WIDE_MODE, MODE_THREE),
      text_row(8'h81, 1'b0),
      // one-cell screen: every glyph and tab wraps both counters
      reg_row(CFG_WIDE_MODE, MODE_SINGLE),
      reg_row(CFG_GLYPH_WIDTH, 16),
      reg_row(CFG_GLYPH_HEIGHT, 32),
      reg_row(CFG_MAX_COLUMNS, 1),
      reg_row(CFG_MAX_ROWS, 1),
      reg_row(CFG_CLEAR_ENABLE, 0),
      text_row(8'h41, 1'b0),
      text_row(CHAR_TAB, 1'b0),
      reg_row(CFG_CLEAR_ENABLE, 1),
      text_row(CHAR_LF, 1'b0)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_transaction(directed_rows[i]);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      apply_setting(phase);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) send_transaction(random_row());
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
